FILE: hdl/fap_pkg.sv
package fap_pkg;

  // Fixed field widths
  localparam int REQ_ID_W = 8;
  localparam int OUT_ID_W = 8;
  localparam int AGE_W    = 8;
  localparam int URG_W    = 8;
  localparam int SEQ_W    = 32;
  // Rank part of a table word: {urgency, age, sequence}
  localparam int RANK_W   = URG_W + AGE_W + SEQ_W;

  // Request codes
  typedef logic [1:0] req_type_t;
  localparam req_type_t REQ_REGISTER  = 2'd0;
  localparam req_type_t REQ_CALL_FIFO = 2'd1;
  localparam req_type_t REQ_CALL_PRIO = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_REGISTERED = 2'd0;
  localparam status_t STAT_SERVED     = 2'd1;
  localparam status_t STAT_EMPTY      = 2'd2;
  localparam status_t STAT_FULL       = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REG,
    ST_A_CHECK,
    ST_A_RDID,
    ST_A_RDMK,
    ST_P_CHECK,
    ST_P_SCAN,
    ST_P_MOVE,
    ST_P_MARK,
    ST_RESP
  } state_t;

  // True when rank a is served before rank b: higher urgency, lower age, lower sequence
  function automatic logic rank_wins(input logic [RANK_W-1:0] a, input logic [RANK_W-1:0] b);
    logic [RANK_W-1:0] key_a;
    logic [RANK_W-1:0] key_b;
    key_a = {a[RANK_W-1 -: URG_W], ~a[SEQ_W +: AGE_W], ~a[SEQ_W-1:0]};
    key_b = {b[RANK_W-1 -: URG_W], ~b[SEQ_W +: AGE_W], ~b[SEQ_W-1:0]};
    return key_a > key_b;
  endfunction

endpackage

FILE: hdl/fap_ram.sv
module fap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/fifo_and_priority_dequeue_lazy_core.sv
// Channel | Direction | Handshake           | Word
// in_     | input     | in_valid / in_stall | req_type, req_id, req_age, req_urgency
// out_    | output    | out_valid/out_stall | status, served_id
//
// Register word: ST_REG, then ST_RESP. Arrival call: ST_A_CHECK, ST_A_RDID, ST_A_RDMK
// per ring entry examined. Priority call: a scan of all live table entries, then
// ST_P_MOVE and ST_P_MARK, per table entry removed; the best entry is found by one
// comparator walking the table RAM one word per cycle. After reset the served-mark RAM
// is cleared one entry a cycle, with in_stall high. One word is in work at a time; the
// next word is taken while the previous result still waits in the output register.
module fifo_and_priority_dequeue_lazy_core #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fap_pkg::req_type_t         in_req_type,
  input  logic [fap_pkg::REQ_ID_W-1:0] in_req_id,
  input  logic [fap_pkg::AGE_W-1:0]  in_req_age,
  input  logic [fap_pkg::URG_W-1:0]  in_req_urgency,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fap_pkg::status_t           out_status,
  output logic [fap_pkg::OUT_ID_W-1:0] out_served_id
);
  import fap_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int MARKS = 1 << ID_BITS;
  localparam int TAB_W = ID_BITS + RANK_W;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]    ring_head_r, ring_head_nxt;
  logic [CNT_W-1:0]    ring_fill_r, ring_fill_nxt;
  logic [CNT_W-1:0]    rank_fill_r, rank_fill_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [ID_BITS-1:0]  clr_r, clr_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [ID_BITS-1:0]  req_id_r, req_id_nxt;
  logic [AGE_W-1:0]    req_age_r, req_age_nxt;
  logic [URG_W-1:0]    req_urg_r, req_urg_nxt;
  logic [TAB_W-1:0]    best_r, best_nxt;
  logic [IDX_W-1:0]    best_k_r, best_k_nxt;
  logic [ID_BITS-1:0]  cur_id_r, cur_id_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [ID_BITS-1:0]  res_id_r, res_id_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [OUT_ID_W-1:0] out_id_r, out_id_nxt;

  // RAM controls
  logic               mk_we, mk_wdata, mk_q;
  logic [ID_BITS-1:0] mk_waddr, mk_raddr;
  logic               rg_we;
  logic [IDX_W-1:0]   rg_waddr, rg_raddr;
  logic [ID_BITS-1:0] rg_wdata, rg_q;
  logic               tb_we;
  logic [IDX_W-1:0]   tb_waddr, tb_raddr;
  logic [TAB_W-1:0]   tb_wdata, tb_q;

  logic [IDX_W:0]     tail_sum;
  logic [IDX_W-1:0]   ring_tail;
  logic [IDX_W-1:0]   head_inc;
  logic               views_full;
  logic               scan_last;
  logic [ID_BITS-1:0] best_id;

  // Served marks, arrival ring and rank table
  fap_ram #(.WIDTH(1), .DEPTH(MARKS)) u_marks (
    .clk(clk), .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
    .rd_addr(mk_raddr), .rd_data(mk_q)
  );

  fap_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_ring (
    .clk(clk), .wr_en(rg_we), .wr_addr(rg_waddr), .wr_data(rg_wdata),
    .rd_addr(rg_raddr), .rd_data(rg_q)
  );

  fap_ram #(.WIDTH(TAB_W), .DEPTH(CAPACITY)) u_table (
    .clk(clk), .wr_en(tb_we), .wr_addr(tb_waddr), .wr_data(tb_wdata),
    .rd_addr(tb_raddr), .rd_data(tb_q)
  );

  // Ring pointer arithmetic
  assign tail_sum  = {1'b0, ring_head_r} + (IDX_W+1)'(ring_fill_r);
  assign ring_tail = (tail_sum >= (IDX_W+1)'(CAPACITY)) ?
                     IDX_W'(tail_sum - (IDX_W+1)'(CAPACITY)) : IDX_W'(tail_sum);
  assign head_inc  = (ring_head_r == LAST_IDX) ? '0 : ring_head_r + 1'b1;

  assign views_full = (ring_fill_r == CAP_CNT) || (rank_fill_r == CAP_CNT) || (seq_r == '1);
  assign scan_last  = (CNT_W'(scan_r) + 1'b1) == rank_fill_r;
  assign best_id    = best_r[TAB_W-1 -: ID_BITS];

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_served_id = out_id_r;

  // Next state, datapath and RAM controls
  always_comb begin
    state_nxt      = state_r;
    ring_head_nxt  = ring_head_r;
    ring_fill_nxt  = ring_fill_r;
    rank_fill_nxt  = rank_fill_r;
    seq_nxt        = seq_r;
    clr_nxt        = clr_r;
    scan_nxt       = scan_r;
    req_id_nxt     = req_id_r;
    req_age_nxt    = req_age_r;
    req_urg_nxt    = req_urg_r;
    best_nxt       = best_r;
    best_k_nxt     = best_k_r;
    cur_id_nxt     = cur_id_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_valid_nxt  = out_valid_r && out_stall;

    mk_we = 1'b0; mk_waddr = '0; mk_wdata = 1'b0; mk_raddr = '0;
    rg_we = 1'b0; rg_waddr = '0; rg_wdata = '0;   rg_raddr = '0;
    tb_we = 1'b0; tb_waddr = '0; tb_wdata = '0;   tb_raddr = '0;

    case (state_r)
      // sweep the served marks after reset
      ST_CLEAR: begin
        mk_we    = 1'b1;
        mk_waddr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          req_id_nxt     = ID_BITS'(in_req_id);
          req_age_nxt    = in_req_age;
          req_urg_nxt    = in_req_urgency;
          res_status_nxt = STAT_EMPTY;
          res_id_nxt     = '0;
          case (in_req_type)
            REQ_REGISTER:  state_nxt = ST_REG;
            REQ_CALL_FIFO: state_nxt = ST_A_CHECK;
            REQ_CALL_PRIO: state_nxt = ST_P_CHECK;
            default:       state_nxt = ST_RESP;
          endcase
        end
      end

      // append to both views
      ST_REG: begin
        if (views_full) begin
          res_status_nxt = STAT_FULL;
        end else begin
          mk_we          = 1'b1;
          mk_waddr       = req_id_r;
          rg_we          = 1'b1;
          rg_waddr       = ring_tail;
          rg_wdata       = req_id_r;
          tb_we          = 1'b1;
          tb_waddr       = IDX_W'(rank_fill_r);
          tb_wdata       = {req_id_r, req_urg_r, req_age_r, seq_r};
          ring_fill_nxt  = ring_fill_r + 1'b1;
          rank_fill_nxt  = rank_fill_r + 1'b1;
          seq_nxt        = seq_r + 1'b1;
          res_status_nxt = STAT_REGISTERED;
        end
        state_nxt = ST_RESP;
      end

      // arrival call: read head id, then its mark
      ST_A_CHECK: begin
        if (ring_fill_r == '0) begin
          state_nxt = ST_RESP;
        end else begin
          rg_raddr  = ring_head_r;
          state_nxt = ST_A_RDID;
        end
      end

      ST_A_RDID: begin
        mk_raddr   = rg_q;
        cur_id_nxt = rg_q;
        state_nxt  = ST_A_RDMK;
      end

      ST_A_RDMK: begin
        ring_head_nxt = head_inc;
        ring_fill_nxt = ring_fill_r - 1'b1;
        if (mk_q) begin
          state_nxt = ST_A_CHECK;
        end else begin
          mk_we          = 1'b1;
          mk_waddr       = cur_id_r;
          mk_wdata       = 1'b1;
          res_status_nxt = STAT_SERVED;
          res_id_nxt     = cur_id_r;
          state_nxt      = ST_RESP;
        end
      end

      // priority call: scan table for the best rank
      ST_P_CHECK: begin
        if (rank_fill_r == '0) begin
          state_nxt = ST_RESP;
        end else begin
          tb_raddr  = '0;
          scan_nxt  = '0;
          state_nxt = ST_P_SCAN;
        end
      end

      ST_P_SCAN: begin
        if (scan_r == '0 || rank_wins(tb_q[RANK_W-1:0], best_r[RANK_W-1:0])) begin
          best_nxt   = tb_q;
          best_k_nxt = scan_r;
        end
        if (scan_last) begin
          tb_raddr  = IDX_W'(rank_fill_r - 1'b1);
          state_nxt = ST_P_MOVE;
        end else begin
          tb_raddr  = scan_r + 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end
      end

      // move last entry into the freed slot, fetch the mark
      ST_P_MOVE: begin
        tb_we         = 1'b1;
        tb_waddr      = best_k_r;
        tb_wdata      = tb_q;
        rank_fill_nxt = rank_fill_r - 1'b1;
        mk_raddr      = best_id;
        state_nxt     = ST_P_MARK;
      end

      ST_P_MARK: begin
        if (!mk_q) begin
          mk_we          = 1'b1;
          mk_waddr       = best_id;
          mk_wdata       = 1'b1;
          res_status_nxt = STAT_SERVED;
          res_id_nxt     = best_id;
          state_nxt      = ST_RESP;
        end else begin
          state_nxt = ST_P_CHECK;
        end
      end

      // hand the result to the output register
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = OUT_ID_W'(res_id_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_head_r <= '0;
      ring_fill_r <= '0;
      rank_fill_r <= '0;
      seq_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ring_head_r <= ring_head_nxt;
      ring_fill_r <= ring_fill_nxt;
      rank_fill_r <= rank_fill_nxt;
      seq_r       <= seq_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    req_id_r     <= req_id_nxt;
    req_age_r    <= req_age_nxt;
    req_urg_r    <= req_urg_nxt;
    best_r       <= best_nxt;
    best_k_r     <= best_k_nxt;
    cur_id_r     <= cur_id_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  // Fill counts stay within capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_fill_r <= CAP_CNT && rank_fill_r <= CAP_CNT)
    else $error("view fill above capacity");

  // Rank fill moves by at most one per cycle
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    rank_fill_r != $past(rank_fill_r) |->
      (rank_fill_r == $past(rank_fill_r) + 1'b1) || (rank_fill_r + 1'b1 == $past(rank_fill_r)))
    else $error("rank fill jumped");

  // Scan never reads past the live part of the table
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_P_SCAN |-> CNT_W'(scan_r) < rank_fill_r)
    else $error("scan index beyond rank fill");

endmodule
